FILE: rtl/core/dwbm_pkg.sv
// Package for the delayed-write bank mapper: transfer payload types,
// opcodes, address constants and the window-to-bank mapping functions.
// Depends on nothing; used by delayed_write_bank_mapper but not by dwbm_ram.
`default_nettype none

package dwbm_pkg;

	localparam int BANK_BYTES  = 2048;
	localparam int STORE_DEPTH = 8192;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [12:0] CTRL_ADDR = 13'h1ff8;
	localparam logic [1:0]  ROM_BANK  = 2'd3;
	localparam logic [2:0]  CC_FIRE   = 3'd5;
	localparam logic [2:0]  CC_IDLE   = 3'd7;

	typedef enum logic [2:0] {
		OP_BUS_READ    = 3'd0,
		OP_BUS_WRITE   = 3'd1,
		OP_DEBUG_READ  = 3'd2,
		OP_PRELOAD     = 3'd3,
		OP_SET_CONTROL = 3'd4
	} opcode_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [12:0] address;
		logic [7:0]  load_data;
	} access_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       cart_drives_bus;
		logic       ram_written;
		logic [7:0] control_now;
	} result_t;

	function automatic logic [1:0] lower_bank(input logic [2:0] sel);
		logic [1:0] b;
		case (sel)
			3'd1, 3'd3: b = 2'd0;
			3'd5, 3'd7: b = 2'd1;
			default:    b = 2'd2;
		endcase
		return b;
	endfunction

	function automatic logic [1:0] upper_bank(input logic [2:0] sel);
		logic [1:0] b;
		case (sel)
			3'd2:       b = 2'd0;
			3'd6:       b = 2'd1;
			3'd3, 3'd7: b = 2'd2;
			default:    b = ROM_BANK;
		endcase
		return b;
	endfunction

	function automatic logic [1:0] window_bank(input logic [12:0] addr, input logic [7:0] ctrl);
		logic [1:0] b;
		b = addr[11] ? upper_bank(ctrl[4:2]) : lower_bank(ctrl[4:2]);
		return b;
	endfunction

	function automatic logic [STORE_AW-1:0] store_index(input logic [12:0] addr,
			input logic [7:0] ctrl);
		int sum;
		sum = int'(window_bank(addr, ctrl)) * BANK_BYTES + int'(addr[10:0]);
		return sum[STORE_AW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dwbm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same address in one cycle return the old data.
// Depends on nothing.
`default_nettype none

module dwbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/delayed_write_bank_mapper.sv
// Top level of the delayed-write bank mapper: address tracking, control byte,
// the 8K bank store and the two-stage result path.
// Depends on dwbm_pkg and dwbm_ram.
//
// Usage: the acc channel carries one access (opcode, address, load_data) per
// transfer; the res channel returns exactly one result per access, in order.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// The bank store read is registered inside the RAM, then the result is
// registered in the output register that drives res_valid.
// Throughput is one access per cycle while acc_stall is low; the tracking
// state and any store write are updated at the edge that accepts the access,
// so each access sees the effects of all earlier ones.
// When the receiver stalls, the output register holds its result and the
// read stage holds the next one; acc_stall rises only when both are full.
// Reset clears the control byte, the latch and the address history and sets
// the change count to idle. The store contents are not cleared and must be
// preloaded or written before they are read.
`default_nettype none

module delayed_write_bank_mapper
	import dwbm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    acc_valid,
	output logic         acc_stall,
	input  wire access_t acc,
	output logic         res_valid,
	input  wire logic    res_stall,
	output result_t      res
);

	logic [7:0]  ctrl_q, ctrl_n;
	logic [7:0]  latched_q, latch_n;
	logic [2:0]  cc_q, cc_n, cc_step;
	logic [12:0] prev_q, prev_n;
	logic        accept;
	logic        wrote, drive, ram_we;
	logic [STORE_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rdata;

	logic        vld_s1, drive_s1, fwd_s1, wrote_s1;
	logic [7:0]  fwd_data_s1, ctrl_s1;
	logic        res_valid_q;
	result_t     res_q;
	logic        out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign acc_stall = vld_s1 && !out_free;
	assign accept    = acc_valid && !acc_stall;

	always_comb begin
		ctrl_n    = ctrl_q;
		latch_n   = latched_q;
		cc_n      = cc_q;
		prev_n    = prev_q;
		wrote     = 1'b0;
		drive     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = acc.address;
		ram_wdata = acc.load_data;
		cc_step   = (acc.address != prev_q) ? cc_q + 3'd1 : cc_q;
		case (acc.opcode)
			OP_BUS_READ, OP_BUS_WRITE: begin
				if (cc_q <= CC_FIRE) begin
					prev_n = acc.address;
					cc_n   = cc_step;
					if (acc.address == CTRL_ADDR) begin
						ctrl_n = latched_q;
						cc_n   = CC_IDLE;
					end else if (cc_step == CC_FIRE && acc.address[12] && ctrl_q[1]) begin
						if (window_bank(acc.address, ctrl_q) != ROM_BANK) begin
							ram_we    = 1'b1;
							ram_waddr = store_index(acc.address, ctrl_q);
							ram_wdata = latched_q;
							wrote     = 1'b1;
						end
						cc_n = CC_IDLE;
					end
				end else if (acc.address[12]) begin
					if (acc.address[11:8] == 4'd0) begin
						latch_n = acc.address[7:0];
						cc_n    = 3'd0;
						prev_n  = acc.address;
					end else if (acc.address == CTRL_ADDR) begin
						ctrl_n = latched_q;
						cc_n   = CC_IDLE;
					end
				end
				drive = (acc.opcode == OP_BUS_READ) && acc.address[12];
			end
			OP_DEBUG_READ: begin
				drive = acc.address[12];
			end
			OP_PRELOAD: begin
				ram_we = 1'b1;
			end
			OP_SET_CONTROL: begin
				ctrl_n = acc.load_data;
			end
			default: begin
			end
		endcase
		ram_raddr = store_index(acc.address, ctrl_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			latched_q <= '0;
			cc_q      <= CC_IDLE;
			prev_q    <= '0;
		end else if (accept) begin
			ctrl_q    <= ctrl_n;
			latched_q <= latch_n;
			cc_q      <= cc_n;
			prev_q    <= prev_n;
		end
	end

	dwbm_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || out_free) begin
			vld_s1 <= accept;
		end
	end

	// A bus read that performs the delayed write reads back the byte just written.
	always_ff @(posedge clk) begin
		if (accept) begin
			drive_s1    <= drive;
			fwd_s1      <= wrote && drive;
			fwd_data_s1 <= latched_q;
			wrote_s1    <= wrote;
			ctrl_s1     <= ctrl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			res_q.read_data       <= !drive_s1 ? 8'd0 : (fwd_s1 ? fwd_data_s1 : ram_rdata);
			res_q.cart_drives_bus <= drive_s1;
			res_q.ram_written     <= wrote_s1;
			res_q.control_now     <= ctrl_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		acc_stall |-> (vld_s1 && res_valid_q))
		else $error("acc_stall raised while the result path has room");

	a_write_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wrote) |=> (cc_q == CC_IDLE))
		else $error("change count not idle after a delayed write");

	a_write_not_rom: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wrote) |-> (ctrl_q[1] && window_bank(acc.address, ctrl_q) != ROM_BANK))
		else $error("delayed write with writes disabled or into the ROM bank");

	a_ctrl_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(accept) |-> $stable(ctrl_q))
		else $error("control byte changed without an accepted transfer");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for delayed_write_bank_mapper: directed and random accesses
// with random idling on both channels, checked against an in-bench prediction of the mapper.
// Depends on dwbm_pkg and the delayed_write_bank_mapper RTL.
module tb_top;
	import dwbm_pkg::*;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
	localparam int         ITEM_TARGET     = 1450;
	localparam int         MAX_REPORTS     = 10;
	// Bank pairs per control scheme, scheme 7 in the top bits.
	localparam logic [15:0] LOWER_MAP = {2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2};
	localparam logic [15:0] UPPER_MAP = {2'd2, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd3, 2'd3};

	typedef struct packed {
		logic [7:0]  ctrl;
		logic [7:0]  latch;
		logic [2:0]  count;
		logic [12:0] prev;
	} tracker_t;

	logic    clk;
	logic    arst_n;
	logic    acc_valid;
	logic    acc_stall;
	access_t acc;
	logic    res_valid;
	logic    res_stall;
	result_t res;

	tracker_t   trk;
	logic [7:0] bank_image [STORE_DEPTH];
	bit         filled [STORE_DEPTH];
	result_t    exp_results [$];
	int         errors;
	int         items_sent;
	int         tx_gap_max;
	int         rx_stall_max;
	int         hold_cycles;

	delayed_write_bank_mapper dut (
		.clk(clk),
		.arst_n(arst_n),
		.acc_valid(acc_valid),
		.acc_stall(acc_stall),
		.acc(acc),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	function automatic logic [1:0] bank_of(input logic [12:0] a, input logic [7:0] c);
		logic [2:0] sel;
		sel = c[4:2];
		return a[11] ? UPPER_MAP[{sel, 1'b0} +: 2] : LOWER_MAP[{sel, 1'b0} +: 2];
	endfunction

	function automatic logic [12:0] image_index(input logic [12:0] a, input logic [7:0] c);
		int s;
		s = int'(bank_of(a, c)) * BANK_BYTES + int'(a[10:0]);
		return s[12:0];
	endfunction

	function automatic logic step_tracker(inout tracker_t s, input logic [12:0] a,
			output logic [12:0] widx);
		logic wrote;
		wrote = 1'b0;
		widx = '0;
		if (s.count <= CC_FIRE) begin
			if (a != s.prev) begin
				s.prev = a;
				s.count = s.count + 3'd1;
			end
			if (a == CTRL_ADDR) begin
				s.ctrl = s.latch;
				s.count = CC_IDLE;
			end else if (s.count == CC_FIRE && a[12] && s.ctrl[1]) begin
				if (bank_of(a, s.ctrl) != ROM_BANK) begin
					widx = image_index(a, s.ctrl);
					wrote = 1'b1;
				end
				s.count = CC_IDLE;
			end
		end else if (a[12]) begin
			if (a[11:8] == 4'd0) begin
				s.latch = a[7:0];
				s.count = '0;
				s.prev = a;
			end else if (a == CTRL_ADDR) begin
				s.ctrl = s.latch;
				s.count = CC_IDLE;
			end
		end
		return wrote;
	endfunction

	function automatic result_t model_access(input access_t x);
		result_t r;
		logic [12:0] widx;
		r = '0;
		case (x.opcode)
			OP_BUS_READ, OP_BUS_WRITE: begin
				r.ram_written = step_tracker(trk, x.address, widx);
				if (r.ram_written) begin
					bank_image[widx] = trk.latch;
					filled[widx] = 1'b1;
				end
				if (x.opcode == OP_BUS_READ && x.address[12]) begin
					r.read_data = bank_image[image_index(x.address, trk.ctrl)];
					r.cart_drives_bus = 1'b1;
				end
			end
			OP_DEBUG_READ: begin
				if (x.address[12]) begin
					r.read_data = bank_image[image_index(x.address, trk.ctrl)];
					r.cart_drives_bus = 1'b1;
				end
			end
			OP_PRELOAD: begin
				bank_image[x.address] = x.load_data;
				filled[x.address] = 1'b1;
			end
			OP_SET_CONTROL: trk.ctrl = x.load_data;
			default: ;
		endcase
		r.control_now = trk.ctrl;
		return r;
	endfunction

	// Reads of never-written store locations are turned into accesses that do not read.
	function automatic access_t avoid_unwritten(input access_t x);
		access_t y;
		tracker_t t;
		logic [12:0] widx;
		logic [12:0] ridx;
		logic wrote;
		y = x;
		if (y.opcode == OP_DEBUG_READ && y.address[12]
				&& !filled[image_index(y.address, trk.ctrl)])
			y.address[12] = 1'b0;
		if (y.opcode == OP_BUS_READ && y.address[12]) begin
			t = trk;
			wrote = step_tracker(t, y.address, widx);
			ridx = image_index(y.address, t.ctrl);
			if (!filled[ridx] && !(wrote && widx == ridx))
				y.opcode = OP_BUS_WRITE;
		end
		return y;
	endfunction

	function automatic logic [12:0] cart_address();
		logic [10:0] off;
		if ($urandom_range(0, 3) == 0)
			off = 11'($urandom);
		else
			off = {($urandom_range(0, 1) != 0) ? 8'hff : 8'h00, 3'($urandom)};
		return {1'b1, 1'($urandom), off};
	endfunction

	function automatic logic [2:0] bus_op();
		return ($urandom_range(0, 1) != 0) ? OP_BUS_READ : OP_BUS_WRITE;
	endfunction

	task automatic send_access(input logic [2:0] op, input logic [12:0] a, input logic [7:0] d);
		access_t x;
		int gap;
		x.opcode = opcode_t'(op);
		x.address = a;
		x.load_data = d;
		x = avoid_unwritten(x);
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			acc_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		acc_valid <= 1'b1;
		acc <= x;
		do @(posedge clk); while (acc_stall);
		exp_results.push_back(model_access(x));
		if (x.opcode <= OP_SET_CONTROL)
			items_sent++;
	endtask

	task automatic report_error(input string what, input result_t want, input result_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%s: expected rd=%h drive=%b wr=%b ctrl=%h, got rd=%h drive=%b wr=%b ctrl=%h",
				what, want.read_data, want.cart_drives_bus, want.ram_written, want.control_now,
				got.read_data, got.cart_drives_bus, got.ram_written, got.control_now);
	endtask

	task automatic send_noise();
		logic [12:0] a;
		a = ($urandom_range(0, 1) != 0) ? cart_address() : 13'($urandom);
		send_access(3'($urandom_range(0, 7)), a, 8'($urandom));
	endtask

	task automatic send_write_sequence();
		logic [12:0] a;
		logic [12:0] prev_addr;
		int k;
		if ($urandom_range(0, 2) == 0)
			send_access(OP_SET_CONTROL, 13'($urandom),
				8'($urandom) | (($urandom_range(0, 1) != 0) ? 8'h02 : 8'h00));
		prev_addr = {5'b10000, 8'($urandom)};
		send_access(bus_op(), prev_addr, 8'($urandom));
		for (k = 0; k < 4; k++) begin
			if ($urandom_range(0, 5) == 0)
				send_access(OP_DEBUG_READ, cart_address(), 8'($urandom));
			a = ($urandom_range(0, 5) == 0) ? prev_addr : 13'($urandom);
			send_access(bus_op(), a, 8'($urandom));
			prev_addr = a;
		end
		a = ($urandom_range(0, 7) == 0) ? CTRL_ADDR : cart_address();
		send_access(bus_op(), a, 8'($urandom));
		if ($urandom_range(0, 1) != 0)
			send_access(OP_DEBUG_READ, a, 8'($urandom));
	endtask

	task automatic test_basic_ops();
		tx_gap_max = 0;
		rx_stall_max = 0;
		send_access(OP_PRELOAD, 13'h1fff, 8'hff);
		send_access(OP_PRELOAD, 13'h1000, 8'h5a);
		send_access(OP_BUS_READ, 13'h1000, 8'h00);
		send_access(OP_DEBUG_READ, 13'h1fff, 8'hff);
		send_access(OP_DEBUG_READ, 13'h0fff, 8'h00);
		send_access(OP_FIRST_UNUSED, 13'h1fff, 8'hff);
		send_access(OP_LAST_UNUSED, 13'h0000, 8'h00);
		send_access(OP_BUS_READ, 13'h0000, 8'h00);
		send_access(OP_SET_CONTROL, 13'h1fff, 8'hff);
	endtask

	task automatic test_delayed_write();
		tx_gap_max = 14;
		rx_stall_max = 14;
		send_access(OP_BUS_WRITE, CTRL_ADDR, 8'h00);
		send_access(OP_SET_CONTROL, 13'h0000, 8'h0a);
		send_access(OP_BUS_WRITE, 13'h1042, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0100, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0100, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0200, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0300, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0400, 8'h00);
		send_access(OP_BUS_READ, 13'h1805, 8'h00);
		// Upper window on ROM: the write must be dropped.
		send_access(OP_SET_CONTROL, 13'h0000, 8'h02);
		send_access(OP_BUS_WRITE, 13'h1011, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0001, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0002, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0003, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0004, 8'h00);
		send_access(OP_BUS_WRITE, 13'h1800, 8'h00);
		send_access(OP_BUS_READ, CTRL_ADDR, 8'h00);
		// Writes disabled: the count runs past five without a write.
		send_access(OP_SET_CONTROL, 13'h0000, 8'h08);
		send_access(OP_BUS_WRITE, 13'h10ff, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0001, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0002, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0003, 8'h00);
		send_access(OP_BUS_WRITE, 13'h0004, 8'h00);
		send_access(OP_BUS_WRITE, 13'h1810, 8'h00);
		send_access(OP_BUS_WRITE, 13'h1811, 8'h00);
	endtask

	task automatic test_backpressure();
		int k;
		tx_gap_max = 0;
		rx_stall_max = 0;
		hold_cycles = 40;
		for (k = 0; k < 16; k++)
			send_noise();
	endtask

	task automatic test_random();
		int b;
		int k;
		tx_gap_max = 3;
		rx_stall_max = 14;
		for (b = 0; b < 4; b++)
			for (k = 0; k < 16; k++)
				send_access(OP_PRELOAD, 13'(b * BANK_BYTES + ((k < 8) ? k : 'h7f0 + k)),
					8'($urandom));
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 30) == 0) begin
				tx_gap_max = ($urandom_range(0, 1) != 0) ? 14 : 0;
				rx_stall_max = ($urandom_range(0, 1) != 0) ? 14 : 0;
			end
			if ($urandom_range(0, 9) < 6)
				send_write_sequence();
			else
				send_noise();
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("delayed_write_bank_mapper test failed");
		$finish;
	end

	initial begin : receiver
		int n;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0)
				n = hold_cycles;
			else
				n = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
			hold_cycles = 0;
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (exp_results.size() == 0) begin
				report_error("unexpected result", '0, res);
			end else begin
				want = exp_results.pop_front();
				if (res.read_data !== want.read_data
						|| res.cart_drives_bus !== want.cart_drives_bus
						|| res.ram_written !== want.ram_written
						|| res.control_now !== want.control_now)
					report_error("result mismatch", want, res);
			end
		end
	end

	initial begin
		trk = '{ctrl: 8'h00, latch: 8'h00, count: CC_IDLE, prev: 13'h0000};
		foreach (filled[i])
			filled[i] = 1'b0;
		errors = 0;
		items_sent = 0;
		tx_gap_max = 0;
		rx_stall_max = 0;
		hold_cycles = 0;
		arst_n <= 1'b0;
		acc_valid <= 1'b0;
		acc <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_delayed_write();
		test_backpressure();
		test_random();
		acc_valid <= 1'b0;
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("delayed_write_bank_mapper test passed");
		else
			$display("delayed_write_bank_mapper test failed");
		$finish;
	end

endmodule
